FILE: design/fps_pkg.sv
// Shared types and constants for the Fenwick prefix-sum table.
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

  localparam int unsigned SIZE_DEF = 1024;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned DATA_W   = 32;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic clear;  // write zero at the sweep address
    logic load;   // capture a new request
    logic walk;   // step one cell along the chain
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;   // sweep is at the last cell
    logic walk_done;  // chain has no more cells
    logic is_query;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/fenwick_prefix_sum_table_top.sv
// Top level of the Fenwick prefix-sum table.
`timescale 1ns / 1ps
`default_nettype none

// Binary indexed tree of SIZE 32-bit cells. A request is taken when start is
// high and busy is low; in_func selects add (delta onto the upward lowbit
// chain of in_index) or prefix-sum query (sum of the downward chain). After
// reset busy stays high while a sweep zeroes the store. A request keeps busy
// high while its chain is walked, one cell per cycle through the store's
// single read and single write port; a query then shows out_prefix_sum with
// out_valid for one cycle, during which busy is low and the next request may
// already be taken. With SIZE = 1024 a chain is at most 10 cells. The result
// cannot be held off: sample it in the cycle out_valid is high.
module fenwick_prefix_sum_table_top #(
  parameter int unsigned SIZE = fps_pkg::SIZE_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_func,
  input  wire logic        [fps_pkg::IDX_W-1:0]  in_index,
  input  wire logic signed [fps_pkg::DATA_W-1:0] in_delta,
  output logic                                   out_valid,
  output logic signed      [fps_pkg::DATA_W-1:0] out_prefix_sum
);
  import fps_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [DATA_W-1:0] acc;

  fps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  fps_dp #(
    .SIZE (SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_func  (in_func),
    .in_index (in_index),
    .in_delta ($unsigned(in_delta)),
    .acc      (acc)
  );

  assign out_prefix_sum = $signed(acc);

`ifndef SYNTHESIS
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_update_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.walk && sts.walk_done && !sts.is_query) |=> !out_valid)
    else $error("update produced a result");

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.walk && sts.walk_done && sts.is_query))
    else $error("result without a finished query");
`endif

endmodule

`default_nettype wire

FILE: design/fps_dp.sv
// Datapath: cell store, chain walker, accumulator and clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

module fps_dp #(
  parameter int unsigned SIZE = fps_pkg::SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fps_pkg::cmd_t               cmd,
  output fps_pkg::sts_t                    sts,
  input  wire logic                        in_func,
  input  wire logic [fps_pkg::IDX_W-1:0]   in_index,
  input  wire logic [fps_pkg::DATA_W-1:0]  in_delta,
  output logic      [fps_pkg::DATA_W-1:0]  acc
);
  import fps_pkg::*;

  localparam int unsigned AW = (SIZE > 1) ? $clog2(SIZE) : 1;
  // position register is one bit wider than index or address so the upward
  // chain can step past the end of the store
  localparam int unsigned PW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [DATA_W-1:0] mem [SIZE];

  logic [PW-1:0]     pos_r;
  logic              func_r;
  logic [DATA_W-1:0] delta_r;
  logic [DATA_W-1:0] acc_r;
  logic [AW-1:0]     clr_addr_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_addr_r;
  logic [DATA_W-1:0] rd_data_r;

  logic [PW-1:0]     low_bit;
  logic [PW-1:0]     pos_nxt;
  logic              pos_in_range;
  logic              issue;
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  always_comb begin
    low_bit      = pos_r & (~pos_r + PW'(1));
    pos_nxt      = (func_r == FUNC_QUERY) ? (pos_r - low_bit) : (pos_r + low_bit);
    pos_in_range = (pos_r != '0) && (pos_r < PW'(SIZE));
    issue        = cmd.walk && pos_in_range;
  end

  always_comb begin
    sts.clr_last  = (clr_addr_r == AW'(SIZE - 1));
    sts.is_query  = (func_r == FUNC_QUERY);
    sts.walk_done = (func_r == FUNC_QUERY) ? (pos_r == '0) : !pos_in_range;
  end

  // one write port: clearing sweep or the read-modify-write of an update
  always_comb begin
    if (cmd.clear) begin
      we = 1'b1;
      wa = clr_addr_r;
      wd = '0;
    end else begin
      we = rd_vld_r && (func_r == FUNC_ADD);
      wa = rd_addr_r;
      wd = rd_data_r + delta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rd_data_r <= mem[pos_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      rd_vld_r <= issue;
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr_r <= pos_r[AW-1:0];
    end
    if (cmd.load) begin
      pos_r   <= PW'(in_index);
      func_r  <= in_func;
      delta_r <= in_delta;
      acc_r   <= '0;
    end else begin
      if (cmd.walk) begin
        pos_r <= pos_nxt;
      end
      if (rd_vld_r && (func_r == FUNC_QUERY)) begin
        acc_r <= acc_r + rd_data_r;
      end
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

FILE: design/fps_ctrl.sv
// Controller: sequences clearing, chain walks and the result strobe.
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire fps_pkg::sts_t sts,
  output fps_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);
  import fps_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_RESP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;
  logic   out_valid_r;
  logic   accept;

  assign accept = start && !busy_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) state_nxt = sts.is_query ? S_RESP : S_IDLE;
      end
      S_RESP: begin
        state_nxt = accept ? S_WALK : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.clear = (state_r == S_CLEAR);
    cmd.load  = accept;
    cmd.walk  = (state_r == S_WALK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= !((state_nxt == S_IDLE) || (state_nxt == S_RESP));
      out_valid_r <= (state_nxt == S_RESP);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
